[src/dfcp_pkg.sv]
package dfcp_pkg;

  localparam logic [7:0] TERM_CHAR = 8'h3B;
  localparam logic [7:0] MARK_CHAR = 8'h24;
  localparam logic [31:0] HELD_RESET = 32'd65535;

  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [2:0] ST_TAKEN     = 3'd0;
  localparam logic [2:0] ST_REPEATED  = 3'd1;
  localparam logic [2:0] ST_NO_OPEN   = 3'd2;
  localparam logic [2:0] ST_NO_CLOSE  = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

endpackage

[src/dfcp_front.sv]
module dfcp_front #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              q_full,
  output logic              q_push,
  output dfcp_pkg::cmd_t    q_cmd
);

  localparam int IW = $clog2(LINE_CAPACITY);
  localparam logic [IW-1:0] LAST = IW'(LINE_CAPACITY - 1);

  logic [IW-1:0] count;
  logic [IW-1:0] count_next;
  logic          accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;

  always_comb begin
    q_push     = 1'b0;
    q_cmd.kind = dfcp_pkg::CMD_STORE;
    q_cmd.data = s_tdata;
    count_next = count;
    if (s_tdata != dfcp_pkg::TERM_CHAR) begin
      q_push = accept;
      if (count < LAST) begin
        q_cmd.kind = dfcp_pkg::CMD_STORE;
        count_next = count + 1'b1;
      end else begin
        // line full: clear it, the byte itself is dropped
        q_cmd.kind = dfcp_pkg::CMD_CLEAR;
        count_next = '0;
      end
    end else if (count != '0) begin
      q_push     = accept;
      q_cmd.kind = dfcp_pkg::CMD_END;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

[src/dfcp_queue.sv]
module dfcp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfcp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output dfcp_pkg::cmd_t pop_cmd
);

  dfcp_pkg::cmd_t entries [dfcp_pkg::QUEUE_DEPTH];
  logic [dfcp_pkg::QUEUE_AW-1:0] wptr;
  logic [dfcp_pkg::QUEUE_AW-1:0] rptr;
  logic [dfcp_pkg::QUEUE_AW:0]   fill;

  assign full    = fill == (dfcp_pkg::QUEUE_AW + 1)'(dfcp_pkg::QUEUE_DEPTH);
  assign valid   = fill != '0;
  assign pop_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && valid) begin
        rptr <= rptr + 1'b1;
      end
      case ({push && !full, pop && valid})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[src/dfcp_back.sv]
module dfcp_back #(
  parameter int LINE_CAPACITY  = 128,
  parameter int FIELD_CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  dfcp_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata     // [2:0] status, [34:3] value, [39:35] zero
);

  localparam int IW = $clog2(LINE_CAPACITY);
  localparam int FW = $clog2(FIELD_CAPACITY + 1);
  localparam logic [FW-1:0] FCAP = FW'(FIELD_CAPACITY);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_CMP   = 2'd1;
  localparam logic [1:0] B_FIX   = 2'd2;
  localparam logic [1:0] B_PARSE = 2'd3;

  localparam logic [1:0] P_OPEN  = 2'd0;
  localparam logic [1:0] P_FIELD = 2'd1;
  localparam logic [1:0] P_DONE  = 2'd2;

  localparam logic [1:0] C_WS   = 2'd0;
  localparam logic [1:0] C_DIG  = 2'd1;
  localparam logic [1:0] C_STOP = 2'd2;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

  logic [7:0] line_mem [LINE_CAPACITY];
  logic [7:0] prev_mem [LINE_CAPACITY];

  logic [1:0]    state;
  logic [IW-1:0] len;
  logic [IW-1:0] prev_len;
  logic [IW-1:0] text_len;
  logic [IW-1:0] ri;
  logic [IW-1:0] pi;
  logic          dv;
  logic          mism;
  logic          equal;
  logic [7:0]    ld;
  logic [7:0]    pd;
  logic [1:0]    ps;
  logic [1:0]    cs;
  logic          neg;
  logic [31:0]   mag;
  logic [FW-1:0] flen;
  logic [31:0]   held;
  logic [2:0]    status;
  logic          out_valid;

  logic          store_we;
  logic          prev_we;
  logic          is_digit;
  logic          is_blank;
  logic          is_sign;
  logic [35:0]   mag_step;
  logic [31:0]   mag_sat;
  logic [1:0]    cs_next;
  logic          neg_next;
  logic [31:0]   mag_next;
  logic [31:0]   conv_value;

  assign q_pop    = (state == B_IDLE) && q_valid &&
                    ((q_cmd.kind != dfcp_pkg::CMD_END) || !out_valid);
  assign store_we = q_pop && (q_cmd.kind == dfcp_pkg::CMD_STORE);
  assign prev_we  = (state == B_PARSE) && dv && (pi != text_len);

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, held, status};

  always_ff @(posedge clk) begin
    if (store_we) begin
      line_mem[len] <= q_cmd.data;
    end
    ld <= line_mem[ri];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[pi] <= ld;
    end
    pd <= prev_mem[ri];
  end

  // atoi-style digit step, magnitude clamped at 2^31
  always_comb begin
    is_digit = (ld >= 8'h30) && (ld <= 8'h39);
    is_blank = (ld == 8'h20) || ((ld >= 8'h09) && (ld <= 8'h0D));
    is_sign  = (ld == 8'h2B) || (ld == 8'h2D);
    mag_step = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, ld[3:0]};
    mag_sat  = (mag_step > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_step[31:0];
    cs_next  = cs;
    neg_next = neg;
    mag_next = mag;
    case (cs)
      C_WS: begin
        if (is_blank) begin
          cs_next = C_WS;
        end else if (is_sign) begin
          neg_next = ld == 8'h2D;
          cs_next  = C_DIG;
        end else if (is_digit) begin
          mag_next = {28'd0, ld[3:0]};
          cs_next  = C_DIG;
        end else begin
          cs_next = C_STOP;
        end
      end
      C_DIG: begin
        if (is_digit) begin
          mag_next = mag_sat;
        end else begin
          cs_next = C_STOP;
        end
      end
      default: cs_next = cs;
    endcase
    if (neg) begin
      conv_value = 32'd0 - mag;
    end else if (mag > POS_LIMIT) begin
      conv_value = POS_LIMIT;
    end else begin
      conv_value = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      len       <= '0;
      prev_len  <= '0;
      held      <= dfcp_pkg::HELD_RESET;
      out_valid <= 1'b0;
      dv        <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            case (q_cmd.kind)
              dfcp_pkg::CMD_STORE: len <= len + 1'b1;
              dfcp_pkg::CMD_CLEAR: len <= '0;
              dfcp_pkg::CMD_END: begin
                state <= B_CMP;
                ri    <= '0;
                dv    <= 1'b0;
                mism  <= 1'b0;
              end
              default: len <= len;
            endcase
          end
        end
        B_CMP: begin
          ri <= ri + 1'b1;
          pi <= ri;
          dv <= 1'b1;
          if (dv) begin
            if ((pi == len) || (ld == 8'd0)) begin
              // text ends at line end or first zero byte
              text_len <= pi;
              equal    <= !mism && (pi == prev_len);
              dv       <= 1'b0;
              state    <= B_FIX;
            end else if ((pi >= prev_len) || (ld != pd)) begin
              mism <= 1'b1;
            end
          end
        end
        B_FIX: begin
          len <= '0;
          if (equal) begin
            status    <= dfcp_pkg::ST_REPEATED;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end else begin
            prev_len <= text_len;
            ri       <= '0;
            dv       <= 1'b0;
            ps       <= P_OPEN;
            cs       <= C_WS;
            neg      <= 1'b0;
            mag      <= '0;
            flen     <= '0;
            state    <= B_PARSE;
          end
        end
        B_PARSE: begin
          ri <= ri + 1'b1;
          pi <= ri;
          dv <= 1'b1;
          if (dv) begin
            if (pi == text_len) begin
              dv        <= 1'b0;
              out_valid <= 1'b1;
              state     <= B_IDLE;
              case (ps)
                P_OPEN:  status <= dfcp_pkg::ST_NO_OPEN;
                P_FIELD: status <= dfcp_pkg::ST_NO_CLOSE;
                default: begin
                  if (flen == '0) begin
                    status <= dfcp_pkg::ST_EMPTY;
                  end else if (flen == FCAP) begin
                    status <= dfcp_pkg::ST_TOO_LONG;
                  end else begin
                    status <= dfcp_pkg::ST_TAKEN;
                    held   <= conv_value;
                  end
                end
              endcase
            end else begin
              case (ps)
                P_OPEN: begin
                  if (ld == dfcp_pkg::MARK_CHAR) begin
                    ps <= P_FIELD;
                  end
                end
                P_FIELD: begin
                  if (ld == dfcp_pkg::MARK_CHAR) begin
                    ps <= P_DONE;
                  end else begin
                    if (flen != FCAP) begin
                      flen <= flen + 1'b1;
                    end
                    cs  <= cs_next;
                    neg <= neg_next;
                    mag <= mag_next;
                  end
                end
                default: ps <= ps;
              endcase
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[src/dollar_field_command_parser_unit.sv]
// Line parser for '$'-delimited numeric commands. Bytes enter on s_* and go
// through a four-entry command queue; the back end stores each byte while it
// is idle. A ';' ending a non-empty line gives one result on m_*: the back end
// walks the stored line once to find its text and compare it with the previous
// line, then once more to copy it and parse the field, one byte a cycle through
// the registered read port of the line memory (a repeated line skips the second
// walk). Bytes keep entering the queue meanwhile until it fills. The line
// memories need no clearing after reset; only control state is reset.
module dollar_field_command_parser_unit #(
  parameter int LINE_CAPACITY  = 128,
  parameter int FIELD_CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata      // [2:0] status, [34:3] value, [39:35] zero
);

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  dfcp_pkg::cmd_t push_cmd;
  dfcp_pkg::cmd_t pop_cmd;

  dfcp_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  dfcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  dfcp_back #(
    .LINE_CAPACITY  (LINE_CAPACITY),
    .FIELD_CAPACITY (FIELD_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[sim/dfcp_line_checker.sv]
module dfcp_line_checker #(
  parameter int LINE_CAP  = 128,
  parameter int FIELD_CAP = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] rx_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,     // [2:0] status, [34:3] value, [39:35] zero
  output int          mismatches,
  output int          lines_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // tab through CR count as blanks, besides space
  localparam logic [7:0] BLANK_LO = 8'h09;
  localparam logic [7:0] BLANK_HI = 8'h0D;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
  } line_result_t;

  line_result_t line_results_q[$];

  logic [7:0]  line_buf [LINE_CAP];
  int unsigned line_len;
  logic [7:0]  prev_text [LINE_CAP];
  int unsigned prev_len;
  logic [31:0] held_value;

  // atoi over line_buf[first..stop), clamped to signed 32 bits
  function automatic logic [31:0] atoi_sat(input int unsigned first,
                                           input int unsigned stop);
    int unsigned i;
    bit neg;
    logic [63:0] mag;
    i = first;
    neg = 1'b0;
    mag = '0;
    while (i < stop && (line_buf[i] == " " ||
           (line_buf[i] >= BLANK_LO && line_buf[i] <= BLANK_HI)))
      i++;
    if (i < stop && (line_buf[i] == "+" || line_buf[i] == "-")) begin
      neg = (line_buf[i] == "-");
      i++;
    end
    while (i < stop && line_buf[i] >= "0" && line_buf[i] <= "9") begin
      mag = mag * 10 + 64'(line_buf[i] - "0");
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      i++;
    end
    if (neg) return 32'd0 - mag[31:0];
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic logic [2:0] field_status(input int unsigned text_len,
                                              output logic [31:0] num);
    int unsigned open_at, close_at, flen;
    num = '0;
    open_at = 0;
    while (open_at < text_len && line_buf[open_at] != dfcp_pkg::MARK_CHAR) open_at++;
    if (open_at >= text_len) return dfcp_pkg::ST_NO_OPEN;
    close_at = open_at + 1;
    while (close_at < text_len && line_buf[close_at] != dfcp_pkg::MARK_CHAR) close_at++;
    if (close_at >= text_len) return dfcp_pkg::ST_NO_CLOSE;
    flen = close_at - open_at - 1;
    if (flen == 0) return dfcp_pkg::ST_EMPTY;
    if (flen >= FIELD_CAP) return dfcp_pkg::ST_TOO_LONG;
    num = atoi_sat(open_at + 1, close_at);
    return dfcp_pkg::ST_TAKEN;
  endfunction

  task automatic take_rx_byte(input logic [7:0] b);
    int unsigned text_len;
    bit same;
    logic [31:0] num;
    line_result_t r;
    if (b != dfcp_pkg::TERM_CHAR) begin
      if (line_len < LINE_CAP - 1) begin
        line_buf[line_len] = b;
        line_len++;
      end else begin
        line_len = 0;  // overflow: line and this byte are dropped
      end
    end else if (line_len != 0) begin
      // text stops at the first NUL
      text_len = 0;
      while (text_len < line_len && line_buf[text_len] != NUL_CHAR) text_len++;
      same = (text_len == prev_len);
      for (int i = 0; i < text_len && same; i++)
        if (line_buf[i] != prev_text[i]) same = 1'b0;
      if (same) begin
        r.status = dfcp_pkg::ST_REPEATED;
      end else begin
        for (int i = 0; i < text_len; i++) prev_text[i] = line_buf[i];
        prev_len = text_len;
        r.status = field_status(text_len, num);
        if (r.status == dfcp_pkg::ST_TAKEN) held_value = num;
      end
      line_len = 0;
      r.value = held_value;
      line_results_q.push_back(r);
    end
  endtask

  task automatic compare_line_result(input logic [39:0] got);
    line_result_t want;
    if (line_results_q.size() == 0) begin
      if (mismatches < 10)
        $display("[%0t] unexpected result: status %0d value %0d", $time,
                 got[2:0], $signed(got[34:3]));
      mismatches++;
    end else begin
      want = line_results_q.pop_front();
      if (got[2:0] !== want.status || got[34:3] !== want.value ||
          got[39:35] !== 5'd0) begin
        if (mismatches < 10)
          $display({"[%0t] mismatch: expected status %0d value %0d, ",
                    "got status %0d value %0d pad %h"},
                   $time, want.status, $signed(want.value), got[2:0],
                   $signed(got[34:3]), got[39:35]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_len = 0;
      prev_len = 0;
      held_value = dfcp_pkg::HELD_RESET;
      line_results_q.delete();
      mismatches = 0;
    end else begin
      if (s_tvalid && s_tready) take_rx_byte(s_tdata);
      if (m_tvalid && m_tready) compare_line_result(m_tdata);
    end
    lines_pending = line_results_q.size();
  end

endmodule

[sim/dollar_field_command_parser_unit_tb.sv]
module dollar_field_command_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 400;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [2:0] status, [34:3] value, [39:35] zero

  int mismatches;
  int lines_pending;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int bytes_sent = 0;
  bit holdoff_req = 1'b0;
  logic holdoff = 1'b0;

  logic [7:0] line_q[$];
  logic [7:0] last_line[$];

  dollar_field_command_parser_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dfcp_line_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (mismatches),
    .lines_pending (lines_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holdoff) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (holdoff_req);
    @(posedge clk);
    holdoff <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holdoff <= 1'b0;
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == 8'h00 || b == dfcp_pkg::TERM_CHAR || b == dfcp_pkg::MARK_CHAR);
    return b;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    line_q.push_back(b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // blanks, optional sign, digits, sometimes a trailing plain byte
  task automatic put_field(input int unsigned ndig);
    repeat ($urandom_range(2))
      put_byte(($urandom_range(5) == 0) ? 8'(" ") : 8'($urandom_range(13, 9)));
    case ($urandom_range(3))
      0: put_byte("-");
      1: put_byte("+");
      default: ;
    endcase
    repeat (ndig) put_byte(8'("0" + $urandom_range(9)));
    if ($urandom_range(3) == 0) put_byte(plain_byte());
  endtask

  task automatic send_line();
    foreach (line_q[i]) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        s_tvalid <= 1'b0;
        s_tdata <= 8'($urandom_range(255));
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= line_q[i];
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    bytes_sent += line_q.size();
    last_line = line_q;
    line_q.delete();
  endtask

  task automatic wait_lines_done();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (lines_pending != 0) @(posedge clk);
  endtask

  task automatic make_random_line();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      repeat ($urandom_range(3)) put_byte(plain_byte());
      put_byte(dfcp_pkg::MARK_CHAR);
      put_field(($urandom_range(7) == 0) ? $urandom_range(20, 11) : $urandom_range(10, 1));
      put_byte(dfcp_pkg::MARK_CHAR);
      repeat ($urandom_range(3))
        put_byte(($urandom_range(3) == 0) ? dfcp_pkg::MARK_CHAR : plain_byte());
      put_byte(dfcp_pkg::TERM_CHAR);
    end else if (pick < 70 && last_line.size() != 0) begin
      line_q = last_line;
    end else if (pick < 82) begin
      case ($urandom_range(4))
        0: repeat ($urandom_range(6, 1)) put_byte(plain_byte());
        1: begin
          put_byte(dfcp_pkg::MARK_CHAR);
          put_field($urandom_range(6));
        end
        2: begin
          // NUL hides the closing mark
          put_byte(dfcp_pkg::MARK_CHAR);
          put_field($urandom_range(4));
          put_byte(8'h00);
          put_byte(dfcp_pkg::MARK_CHAR);
        end
        3: begin
          put_byte(dfcp_pkg::MARK_CHAR);
          put_byte(dfcp_pkg::MARK_CHAR);
        end
        default: begin
          put_byte(dfcp_pkg::MARK_CHAR);
          put_field($urandom_range(40, 29));
          put_byte(dfcp_pkg::MARK_CHAR);
        end
      endcase
      put_byte(dfcp_pkg::TERM_CHAR);
    end else if (pick < 99) begin
      repeat ($urandom_range(8, 1)) put_byte(8'($urandom_range(255)));
      if ($urandom_range(1) == 1) put_byte(dfcp_pkg::TERM_CHAR);
    end else begin
      // long line, often past capacity
      repeat ($urandom_range(134, 120)) put_byte(plain_byte());
      put_byte(dfcp_pkg::MARK_CHAR);
      put_field(2);
      put_byte(dfcp_pkg::MARK_CHAR);
      put_byte(dfcp_pkg::TERM_CHAR);
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int nbytes);
    int start_count;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start_count = bytes_sent;
    while (bytes_sent - start_count < nbytes) begin
      make_random_line();
      send_line();
    end
    wait_lines_done();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // NUL-only text matches the empty previous line after reset
    put_byte(8'h00); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$5$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$5$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("abc"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$12"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    // widest field accepted, then one character too many
    put_byte(dfcp_pkg::MARK_CHAR); repeat (29) put_byte("0"); put_str("42$");
    put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_byte(dfcp_pkg::MARK_CHAR); repeat (31) put_byte("0"); put_str("7$");
    put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$-99999999999$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$+2147483648$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$-2147483648$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$");
    for (int c = 9; c <= 13; c++) put_byte(8'(c));
    put_str(" -0017x$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$  $"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_byte(8'hFF); put_str("$7$"); put_byte(8'h80);
    put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$8"); put_byte(8'h00); put_str("$");
    put_byte(dfcp_pkg::TERM_CHAR); send_line();
    // full line: the extra byte clears it
    repeat (127) put_byte("x");
    put_str("y$9$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$3$"); repeat (124) put_byte("z");
    put_byte(dfcp_pkg::TERM_CHAR); send_line();
    put_str("$2147483647$"); put_byte(dfcp_pkg::TERM_CHAR); send_line();
    wait_lines_done();

    // sender at full rate against a stalled receiver
    holdoff_req = 1'b1;
    repeat (20) begin
      make_random_line();
      send_line();
    end
    wait_lines_done();

    run_phase(0, 0, 400);
    run_phase(59, 0, 400);
    run_phase(0, 59, 400);
    run_phase(12, 12, 400);

    wait_lines_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && lines_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[dollar_field_command_parser_unit.f]
src/dfcp_pkg.sv
src/dfcp_front.sv
src/dfcp_queue.sv
src/dfcp_back.sv
src/dollar_field_command_parser_unit.sv
sim/dfcp_line_checker.sv
sim/dollar_field_command_parser_unit_tb.sv
